// ===== rtl/skf_pkg.sv =====
// Shared widths, register indexes, reset values and datapath bundles for the Kalman filter
package skf_pkg;

  localparam int MEAS_WIDTH    = 16;
  localparam int VAR_FRAC_BITS = 24;
  localparam int WORD_W        = 32;
  localparam int EST_FRAC_BITS = 16;

  localparam int GAIN_W = VAR_FRAC_BITS + 1;
  localparam int K_W    = GAIN_W;
  localparam int DEN_W  = WORD_W + 1;
  localparam int REM_W  = WORD_W + 2;
  localparam int ZQ_W   = MEAS_WIDTH + EST_FRAC_BITS;
  localparam int DIFF_W = ((ZQ_W > WORD_W) ? ZQ_W : WORD_W) + 1;
  localparam int MAG_W  = DIFF_W;
  localparam int XN_W   = DIFF_W + 1;
  localparam int PM_W   = MAG_W + K_W;
  localparam int PP_W   = WORD_W + K_W;
  localparam int CNT_W  = $clog2(K_W);

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE = CFG_IDX_W'(3);

  localparam logic [WORD_W-1:0] RST_PROCESS_NOISE = WORD_W'(33554);
  localparam logic [WORD_W-1:0] RST_MEAS_NOISE    = WORD_W'(838861);
  localparam logic [WORD_W-1:0] RST_INIT_ESTIMATE = WORD_W'(2949120);
  localparam logic [WORD_W-1:0] RST_INIT_VARIANCE = WORD_W'(134218);

  localparam logic [K_W-1:0] K_ONE = {1'b1, {VAR_FRAC_BITS{1'b0}}};

  localparam logic [WORD_W-1:0] EST_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] EST_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic [WORD_W-1:0] pp;
    logic [DEN_W-1:0]  den;
    logic [MAG_W-1:0]  mag;
  } skf_ops_t;

  typedef struct packed {
    logic [K_W-1:0]  k;
    logic [PM_W-1:0] prod_mag;
    logic [PP_W-1:0] prod_pp;
  } skf_res_t;

endpackage

// ===== rtl/skf_if.sv =====
// Valid/ready channel interfaces for measurement beats and result beats
interface skf_in_if;
  import skf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [MEAS_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface skf_out_if;
  import skf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] estimate;
  logic [GAIN_W-1:0]        gain;
  logic [WORD_W-1:0]        variance;

  modport source (output valid, output estimate, output gain, output variance, input ready);
  modport sink (input valid, input estimate, input gain, input variance, output ready);
endinterface

// ===== rtl/skf_serial_unit.sv =====
// Radix-2 gain divider with two MSB-first shift-add multipliers fed by its quotient bits
module skf_serial_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  skf_pkg::skf_ops_t ops,
  output logic              busy,
  output skf_pkg::skf_res_t res
);
  import skf_pkg::*;

  logic [REM_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic             den_zero;
  logic [MAG_W-1:0] mag;
  logic [WORD_W-1:0] pp;
  logic [CNT_W-1:0] cnt;
  logic [K_W-1:0]   k;
  logic [PM_W-1:0]  acc_mag;
  logic [PP_W-1:0]  acc_pp;

  logic             qbit;
  logic [REM_W-1:0] rem_sel;
  logic [REM_W-1:0] rem_next;
  logic [PM_W-1:0]  acc_mag_next;
  logic [PP_W-1:0]  acc_pp_next;

  always_comb begin
    qbit         = !den_zero && (rem >= REM_W'(den));
    rem_sel      = qbit ? (rem - REM_W'(den)) : rem;
    rem_next     = {rem_sel[REM_W-2:0], 1'b0};
    acc_mag_next = {acc_mag[PM_W-2:0], 1'b0} + (qbit ? PM_W'(mag) : '0);
    acc_pp_next  = {acc_pp[PP_W-2:0], 1'b0} + (qbit ? PP_W'(pp) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(K_W - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= REM_W'(ops.pp);
      den      <= ops.den;
      den_zero <= (ops.den == '0);
      mag      <= ops.mag;
      pp       <= ops.pp;
      k        <= '0;
      acc_mag  <= '0;
      acc_pp   <= '0;
    end else if (busy) begin
      rem     <= rem_next;
      k       <= {k[K_W-2:0], qbit};
      acc_mag <= acc_mag_next;
      acc_pp  <= acc_pp_next;
    end
  end

  assign res.k        = k;
  assign res.prod_mag = acc_mag;
  assign res.prod_pp  = acc_pp;

endmodule

// ===== rtl/scalar_kalman_filter_unit.sv =====
// Top level of the one-dimensional fixed-point Kalman filter
//
//   channel   dir  handshake       contents
//   samples   in   valid/ready     measurement z, signed integer
//   results   out  valid/ready     estimate Q16.16, gain Q1.24, variance
//   cfg       in   cfg_write       cfg_index, cfg_data (no read-back)
//
// Each measurement is accepted, passes a setup state, runs through the
// bit-serial divider (one gain bit per cycle, both products built alongside),
// and the result is then formed and registered.
// Reset loads the register defaults and copies the init values into the state.
// A result beat waits in its output register; a new sample is taken meanwhile,
// and the unit holds in its last cycle only while that register is still full.
module scalar_kalman_filter_unit (
  input  logic                             clk,
  input  logic                             rst,
  skf_in_if.sink                           samples,
  skf_out_if.source                        results,
  input  logic                             cfg_write,
  input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [skf_pkg::WORD_W-1:0]       cfg_data
);
  import skf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0] state;

  logic [WORD_W-1:0]        process_noise;
  logic [WORD_W-1:0]        meas_noise;
  logic signed [WORD_W-1:0] estimate_reg;
  logic [WORD_W-1:0]        variance_reg;

  logic [WORD_W-1:0]            pp_r;
  logic signed [MEAS_WIDTH-1:0] meas_r;
  logic                         neg;

  logic                     out_valid;
  logic signed [WORD_W-1:0] out_estimate;
  logic [GAIN_W-1:0]        out_gain;
  logic [WORD_W-1:0]        out_variance;

  logic        take;
  logic        finish;
  logic [WORD_W:0]   pp_sum;
  logic [WORD_W-1:0] pp_sat;

  logic signed [ZQ_W-1:0]   zq;
  logic signed [DIFF_W-1:0] diff;
  skf_ops_t                 ops;
  skf_res_t                 res;
  logic                     busy;

  logic signed [XN_W-1:0]   est_ext;
  logic signed [XN_W-1:0]   corr;
  logic signed [XN_W-1:0]   xn;
  logic [XN_W-WORD_W:0]     xn_hi;
  logic [WORD_W-1:0]        est_sat;
  logic [WORD_W:0]          p_ceil;
  logic [WORD_W-1:0]        p_new;

  assign samples.ready = (state == ST_IDLE);
  assign take          = samples.valid && samples.ready;
  assign finish        = (state == ST_RUN) && !busy && (!out_valid || results.ready);

  always_comb begin
    pp_sum = {1'b0, variance_reg} + {1'b0, process_noise};
    pp_sat = pp_sum[WORD_W] ? {WORD_W{1'b1}} : pp_sum[WORD_W-1:0];

    zq   = {meas_r, {EST_FRAC_BITS{1'b0}}};
    diff = DIFF_W'(zq) - DIFF_W'(estimate_reg);

    ops.pp  = pp_r;
    ops.den = DEN_W'(pp_r) + DEN_W'(meas_noise);
    ops.mag = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    est_ext = XN_W'(estimate_reg);
    corr    = $signed(res.prod_mag[PM_W-1:VAR_FRAC_BITS]);
    xn      = neg ? (est_ext - corr) : (est_ext + corr);
    xn_hi   = xn[XN_W-1:WORD_W-1];
    if ((&xn_hi) || !(|xn_hi)) begin
      est_sat = xn[WORD_W-1:0];
    end else begin
      est_sat = xn[XN_W-1] ? EST_MIN : EST_MAX;
    end

    p_ceil = res.prod_pp[PP_W-1:VAR_FRAC_BITS]
           + (WORD_W+1)'(|res.prod_pp[VAR_FRAC_BITS-1:0]);
    p_new  = pp_r - p_ceil[WORD_W-1:0];
  end

  skf_serial_unit u_serial (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_PREP),
    .ops   (ops),
    .busy  (busy),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: state <= ST_RUN;
        ST_RUN: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pp_r   <= pp_sat;
      meas_r <= samples.measurement;
    end
    if (state == ST_PREP) begin
      neg <= diff[DIFF_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= RST_PROCESS_NOISE;
      meas_noise    <= RST_MEAS_NOISE;
      estimate_reg  <= RST_INIT_ESTIMATE;
      variance_reg  <= RST_INIT_VARIANCE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEAS_NOISE:    meas_noise    <= cfg_data;
        REG_INIT_ESTIMATE: estimate_reg  <= cfg_data;
        REG_INIT_VARIANCE: variance_reg  <= cfg_data;
        default: ;
      endcase
    end else if (finish) begin
      estimate_reg <= est_sat;
      variance_reg <= p_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_estimate <= est_sat;
      out_gain     <= res.k;
      out_variance <= p_new;
    end
  end

  assign results.valid    = out_valid;
  assign results.estimate = out_estimate;
  assign results.gain     = out_gain;
  assign results.variance = out_variance;

  a_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_PREP |=> busy)
    else $error("serial unit did not start");

  a_gain: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.gain <= K_ONE)
    else $error("gain above one");

  a_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == ST_RUN)
    else $error("result beat raised outside the final cycle");

  a_var: assert property (@(posedge clk) disable iff (rst)
    finish && !cfg_write |=> variance_reg <= $past(pp_r))
    else $error("updated variance exceeds predicted variance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    busy |-> state == ST_RUN)
    else $error("serial unit running outside the run state");

endmodule
